// File: rtl/fbmvn_pkg.sv
// ---------------------------------------------------------------------------
// fbmvn_pkg
// Shared types and constants of the fractal value noise pipeline.
// ---------------------------------------------------------------------------
package fbmvn_pkg;

  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 24;
  localparam int LAC_W      = 20;
  localparam int GAIN_W     = 16;
  localparam int NOISE_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 32;
  localparam int SUM_W      = 35;
  localparam int OCT_LAT    = 19;
  localparam int CORNERS    = 8;

  typedef logic [63:0]      q32_t;
  typedef q32_t [2:0]       point_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;
  localparam logic [LAC_W-1:0]   LAC_RST   = 20'd131072;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd32768;

  localparam logic [25:0] HASH_K     = 26'd43383465;
  localparam logic [35:0] SEVEN_HALF = 36'h7_8000_0000;
  localparam logic [33:0] THREE_Q32  = 34'h3_0000_0000;
  localparam q32_t        SHIFT_100  = 64'h0000_0064_0000_0000;
  localparam q32_t        SHIFT_101  = 64'h0000_0064_0000_0001;
  localparam frac_t       AMP_INIT   = 32'h8000_0000;

  localparam logic [31:0] CELL_KX = 32'd110;
  localparam logic [31:0] CELL_KY = 32'd241;
  localparam logic [31:0] CELL_KZ = 32'd171;

  localparam logic [31:0] CORNER_OFS [CORNERS] = '{
    32'd0, 32'd110, 32'd241, 32'd351, 32'd171, 32'd281, 32'd412, 32'd522
  };

endpackage

// File: rtl/fbmvn_delay.sv
// ---------------------------------------------------------------------------
// fbmvn_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ---------------------------------------------------------------------------
module fbmvn_delay #(
  parameter int W = 32,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[D-1];

endmodule

// File: rtl/fbmvn_hash.sv
// ---------------------------------------------------------------------------
// fbmvn_hash
// Six-stage cell hash: fract(p*k), h*(h+7.5), h*2h, fract.
// ---------------------------------------------------------------------------
module fbmvn_hash (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [31:0]         p_i,
  output fbmvn_pkg::frac_t    h_o
);
  import fbmvn_pkg::*;

  logic        neg1_q, neg2_q;
  logic [31:0] mag_q, m1_q, m1b_q;
  logic [35:0] g_q, m2_q, ab_q;
  logic [63:0] bb_q, sq;
  logic [57:0] kprod;
  logic [67:0] gprod;
  frac_t       h_q;

  assign kprod = mag_q * HASH_K;
  assign gprod = m1b_q * g_q;
  assign sq    = bb_q + {ab_q[30:0], 33'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= p_i[31];
      mag_q  <= p_i[31] ? (32'd0 - p_i) : p_i;
      neg2_q <= neg1_q;
      m1_q   <= kprod[31:0];
      m1b_q  <= m1_q;
      g_q    <= neg2_q ? (SEVEN_HALF - {4'd0, m1_q}) : (SEVEN_HALF + {4'd0, m1_q});
      m2_q   <= gprod[67:32];
      bb_q   <= m2_q[31:0] * m2_q[31:0];
      ab_q   <= m2_q[35:32] * m2_q[31:0];
      h_q    <= sq[62:31];
    end
  end

  assign h_o = h_q;

endmodule

// File: rtl/fbmvn_lerp.sv
// ---------------------------------------------------------------------------
// fbmvn_lerp
// Three-stage interpolation a + (b - a) * t on unsigned fractions.
// ---------------------------------------------------------------------------
module fbmvn_lerp (
  input  logic             clk_i,
  input  logic             en_i,
  input  fbmvn_pkg::frac_t a_i,
  input  fbmvn_pkg::frac_t b_i,
  input  fbmvn_pkg::frac_t t_i,
  output fbmvn_pkg::frac_t y_o
);
  import fbmvn_pkg::*;

  logic        neg1_q, neg2_q;
  frac_t       mag_q, a1_q, a2_q, t_q, pr_q, y_q;
  logic [63:0] prod;

  assign prod = mag_q * t_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= (b_i < a_i);
      mag_q  <= (b_i < a_i) ? (a_i - b_i) : (b_i - a_i);
      a1_q   <= a_i;
      t_q    <= t_i;
      neg2_q <= neg1_q;
      a2_q   <= a1_q;
      pr_q   <= prod[63:32];
      y_q    <= neg2_q ? (a2_q - pr_q) : (a2_q + pr_q);
    end
  end

  assign y_o = y_q;

endmodule

// File: rtl/fbmvn_octave.sv
// ---------------------------------------------------------------------------
// fbmvn_octave
// One octave: trilinear value noise, weighted sum and coordinate update.
// ---------------------------------------------------------------------------
module fbmvn_octave (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [fbmvn_pkg::LAC_W-1:0]   lacunarity_i,
  input  logic [fbmvn_pkg::GAIN_W-1:0]  gain_i,
  input  fbmvn_pkg::point_t             pt_i,
  input  fbmvn_pkg::frac_t              amp_i,
  input  fbmvn_pkg::sum_t               sum_i,
  output fbmvn_pkg::point_t             pt_o,
  output fbmvn_pkg::frac_t              amp_o,
  output fbmvn_pkg::sum_t               sum_o
);
  import fbmvn_pkg::*;

  logic [31:0] n_q;
  logic [31:0] p_q [CORNERS];
  frac_t       f2_q [3];
  logic [33:0] tm_q [3];
  frac_t       u_q [3];
  frac_t       ux, uy, uz;
  frac_t       hash_w [CORNERS];
  frac_t       lv1 [4];
  frac_t       lv2 [2];
  frac_t       noise_v, amp_dly, term_q;
  sum_t        sum_dly, sum_q;
  logic [47:0] amp_prod;
  frac_t       amp_nx_q;
  logic [63:0] term_prod;
  q32_t        mag_q [3];
  logic        neg1_q [3], neg2_q [3], neg3_q [3];
  logic [51:0] ph_q [3], pl_q [3];
  q32_t        r_q [3];
  point_t      c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= pt_i[0][63:32] * CELL_KX + pt_i[1][63:32] * CELL_KY
           + pt_i[2][63:32] * CELL_KZ;
      for (int k = 0; k < CORNERS; k++) begin
        p_q[k] <= n_q + CORNER_OFS[k];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [63:0] fsq;
    logic [65:0] uprod;
    logic [67:0] lac_cat;

    assign fsq   = pt_i[a][31:0] * pt_i[a][31:0];
    assign uprod = f2_q[a] * tm_q[a];
    assign lac_cat = {ph_q[a], 16'd0};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f2_q[a]   <= fsq[63:32];
        tm_q[a]   <= THREE_Q32 - {1'b0, pt_i[a][31:0], 1'b0};
        u_q[a]    <= uprod[63:32];
        neg1_q[a] <= pt_i[a][63];
        mag_q[a]  <= pt_i[a][63] ? (64'd0 - pt_i[a]) : pt_i[a];
        neg2_q[a] <= neg1_q[a];
        ph_q[a]   <= mag_q[a][63:32] * lacunarity_i;
        pl_q[a]   <= mag_q[a][31:0] * lacunarity_i;
        neg3_q[a] <= neg2_q[a];
        r_q[a]    <= lac_cat[63:0] + {28'd0, pl_q[a][51:16]};
        c_q[a]    <= neg3_q[a] ? (~r_q[a] + SHIFT_101) : (r_q[a] + SHIFT_100);
      end
    end
  end

  for (genvar k = 0; k < CORNERS; k++) begin : g_hash
    fbmvn_hash u_hash (
      .clk_i (clk_i),
      .en_i  (en_i),
      .p_i   (p_q[k]),
      .h_o   (hash_w[k])
    );
  end

  fbmvn_delay #(.W(FRAC_W), .D(6)) u_dly_ux (
    .clk_i (clk_i), .en_i (en_i), .d_i (u_q[0]), .q_o (ux)
  );
  fbmvn_delay #(.W(FRAC_W), .D(9)) u_dly_uy (
    .clk_i (clk_i), .en_i (en_i), .d_i (u_q[1]), .q_o (uy)
  );
  fbmvn_delay #(.W(FRAC_W), .D(12)) u_dly_uz (
    .clk_i (clk_i), .en_i (en_i), .d_i (u_q[2]), .q_o (uz)
  );

  for (genvar j = 0; j < 4; j++) begin : g_lx
    fbmvn_lerp u_lerp (
      .clk_i (clk_i), .en_i (en_i),
      .a_i (hash_w[2*j]), .b_i (hash_w[2*j+1]), .t_i (ux), .y_o (lv1[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_ly
    fbmvn_lerp u_lerp (
      .clk_i (clk_i), .en_i (en_i),
      .a_i (lv1[2*j]), .b_i (lv1[2*j+1]), .t_i (uy), .y_o (lv2[j])
    );
  end

  fbmvn_lerp u_lerp_z (
    .clk_i (clk_i), .en_i (en_i),
    .a_i (lv2[0]), .b_i (lv2[1]), .t_i (uz), .y_o (noise_v)
  );

  fbmvn_delay #(.W(FRAC_W), .D(17)) u_dly_amp (
    .clk_i (clk_i), .en_i (en_i), .d_i (amp_i), .q_o (amp_dly)
  );
  fbmvn_delay #(.W(SUM_W), .D(18)) u_dly_sum (
    .clk_i (clk_i), .en_i (en_i), .d_i (sum_i), .q_o (sum_dly)
  );

  assign term_prod = amp_dly * noise_v;
  assign amp_prod  = amp_i * gain_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q   <= term_prod[63:32];
      sum_q    <= sum_dly + {{(SUM_W - FRAC_W){1'b0}}, term_q};
      amp_nx_q <= amp_prod[47:16];
    end
  end

  fbmvn_delay #(.W(FRAC_W), .D(OCT_LAT - 1)) u_dly_ampnx (
    .clk_i (clk_i), .en_i (en_i), .d_i (amp_nx_q), .q_o (amp_o)
  );
  fbmvn_delay #(.W(192), .D(OCT_LAT - 4)) u_dly_pt (
    .clk_i (clk_i), .en_i (en_i), .d_i (c_q), .q_o (pt_o)
  );

  assign sum_o = sum_q;

endmodule

// File: rtl/fbm_value_noise_3d.sv
// ---------------------------------------------------------------------------
// fbm_value_noise_3d
// Fractal Brownian motion over 3D value noise, fully pipelined.
// ---------------------------------------------------------------------------
// The block takes one point per cycle while not stalled. Each point passes
// one scaling stage, then a 19-stage octave unit per octave, each holding
// eight hash pipelines, seven interpolators and the coordinate update.
// The whole pipeline advances together; it halts only while a finished
// beat waits in the output register and another has reached the last
// stage.
module fbm_value_noise_3d #(
  parameter int OCTAVES = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [fbmvn_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [fbmvn_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [fbmvn_pkg::COORD_W-1:0] coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fbmvn_pkg::NOISE_W-1:0]     noise_value_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fbmvn_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbmvn_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fbmvn_pkg::*;

  localparam int LAT = 1 + OCT_LAT * OCTAVES;

  logic [SCALE_W-1:0] scale_q;
  logic [LAC_W-1:0]   lac_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LAT-1:0]     vld_q;
  logic               en;
  logic               out_valid_q;
  logic [NOISE_W-1:0] noise_q;
  point_t             pt0_q;
  point_t             pt_w [OCTAVES+1];
  frac_t              amp_w [OCTAVES+1];
  sum_t               sum_w [OCTAVES+1];
  logic signed [56:0] sprod [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      lac_q   <= LAC_RST;
      gain_q  <= GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_LAC:   lac_q   <= cfg_data_i[LAC_W-1:0];
        CFG_GAIN:  gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i && vld_q[LAT-1]);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (en && vld_q[LAT-1]) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sprod[0] = coord_x_i * $signed({1'b0, scale_q});
  assign sprod[1] = coord_y_i * $signed({1'b0, scale_q});
  assign sprod[2] = coord_z_i * $signed({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        pt0_q[a] <= {{7{sprod[a][56]}}, sprod[a]};
      end
    end
  end

  assign pt_w[0]  = pt0_q;
  assign amp_w[0] = AMP_INIT;
  assign sum_w[0] = '0;

  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    fbmvn_octave u_octave (
      .clk_i        (clk_i),
      .en_i         (en),
      .lacunarity_i (lac_q),
      .gain_i       (gain_q),
      .pt_i         (pt_w[k]),
      .amp_i        (amp_w[k]),
      .sum_i        (sum_w[k]),
      .pt_o         (pt_w[k+1]),
      .amp_o        (amp_w[k+1]),
      .sum_o        (sum_w[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[LAT-1]) begin
      noise_q <= {{(NOISE_W - SUM_W + 16){1'b0}}, sum_w[OCTAVES][SUM_W-1:16]};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

// File: sim/fbm_value_noise_3d_tb.sv
// ---------------------------------------------------------------------------
// fbm_value_noise_3d_tb
// Self-checking testbench for the fractal value noise pipeline.
// ---------------------------------------------------------------------------
// A short table of corner points runs first at the reset settings. Random
// points follow under several register settings, including the extremes.
// Every result is compared with a fixed-point noise predictor. Both sides
// idle at random, and once the receiver holds off long enough to fill the
// pipeline.
`timescale 1ns / 1ps

module fbm_value_noise_3d_tb;
  import fbmvn_pkg::*;

  localparam int OCT       = 6;
  localparam int LATENCY   = 1 + 19 * OCT;
  localparam int WDOG_MAX  = 4000;
  localparam int HOLD_LEN  = 400;
  localparam int PHASE_LEN = 250;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] coord_x_i = '0;
  logic signed [COORD_W-1:0] coord_y_i = '0;
  logic signed [COORD_W-1:0] coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [NOISE_W-1:0] noise_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [SCALE_W-1:0] scale_reg;
  logic [LAC_W-1:0] lac_reg;
  logic [GAIN_W-1:0] gain_reg;

  logic [NOISE_W-1:0] noise_expected[$];
  int errors = 0;
  int idle_pct = 32;
  int wdog = 0;
  bit hold_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fbm_value_noise_3d #(.OCTAVES(OCT)) u_dut (.*);

  function automatic q32_t qmul(q32_t a, q32_t b);
    logic neg;
    q32_t ma, mb, r;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = {64'b0, ma} * {64'b0, mb};
    r = p[95:32];
    return neg ? -r : r;
  endfunction

  function automatic q32_t fract_tz(q32_t v);
    q32_t m;
    if (v[63]) begin
      m = (-v) & 64'hFFFF_FFFF;
      return -m;
    end
    return {32'b0, v[31:0]};
  endfunction

  function automatic q32_t cell_hash(logic [31:0] p);
    q32_t h;
    h = fract_tz(qmul({p, 32'b0}, 64'(HASH_K)));
    h = qmul(h, h + 64'(SEVEN_HALF));
    h = qmul(h, h + h);
    return fract_tz(h);
  endfunction

  function automatic q32_t blend(q32_t a, q32_t b, q32_t t);
    return a + qmul(b - a, t);
  endfunction

  function automatic q32_t smoothstep(logic [31:0] f);
    q32_t fq;
    fq = {32'b0, f};
    return qmul(qmul(fq, fq), 64'(THREE_Q32) - 2 * fq);
  endfunction

  function automatic q32_t value_noise(point_t c);
    logic [31:0] n;
    q32_t ux, uy, uz, a0, a1, a2, a3;
    n = c[0][63:32] * 32'd110 + c[1][63:32] * 32'd241 + c[2][63:32] * 32'd171;
    ux = smoothstep(c[0][31:0]);
    uy = smoothstep(c[1][31:0]);
    uz = smoothstep(c[2][31:0]);
    a0 = blend(cell_hash(n), cell_hash(n + 32'd110), ux);
    a1 = blend(cell_hash(n + 32'd241), cell_hash(n + 32'd351), ux);
    a2 = blend(cell_hash(n + 32'd171), cell_hash(n + 32'd281), ux);
    a3 = blend(cell_hash(n + 32'd412), cell_hash(n + 32'd522), ux);
    return blend(blend(a0, a1, uy), blend(a2, a3, uy), uz);
  endfunction

  function automatic logic [NOISE_W-1:0] fbm_noise(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
    point_t c;
    q32_t amp, total, lac_q, gain_q;
    amp = 64'h8000_0000;
    total = '0;
    lac_q = {28'b0, lac_reg, 16'b0};
    gain_q = {32'b0, gain_reg, 16'b0};
    c[0] = {{32{x[31]}}, x} * {40'b0, scale_reg};
    c[1] = {{32{y[31]}}, y} * {40'b0, scale_reg};
    c[2] = {{32{z[31]}}, z} * {40'b0, scale_reg};
    for (int k = 0; k < OCT; k++) begin
      total += qmul(amp, value_noise(c));
      for (int i = 0; i < 3; i++) c[i] = qmul(c[i], lac_q) + SHIFT_100;
      amp = qmul(amp, gain_q);
    end
    if (total[63]) total = '0;
    total = total >> 16;
    if (total > 64'hF_FFFF) total = 64'hF_FFFF;
    return total[NOISE_W-1:0];
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    noise_expected.push_back(fbm_noise(x, y, z));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SCALE: scale_reg = data[SCALE_W-1:0];
      CFG_LAC:   lac_reg = data[LAC_W-1:0];
      CFG_GAIN:  gain_reg = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20000)) - 10000) << 8;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected beat, noise_value %h", $time, noise_value_o);
          errors++;
        end else begin
          if (noise_value_o !== noise_expected[0]) begin
            $display("%0t: noise_value expected %h actual %h", $time,
                     noise_expected[0], noise_value_o);
            errors++;
          end
          void'(noise_expected.pop_front());
        end
      end
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("fbm_value_noise_3d test failed");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  initial begin
    point_row_t rows[$];
    logic [CFG_DATA_W-1:0] phase_cfg[6][3];
    scale_reg = SCALE_RST;
    lac_reg = LAC_RST;
    gain_reg = GAIN_RST;
    rows = '{
      '{32'h0, 32'h0, 32'h0}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '{32'hFFFF_FFFF, 32'h0, 32'h1},
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, '{32'hFFFF_0000, 32'hFFFE_8000, 32'h0},
      '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000}, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0},
      '{32'h0000_FFFF, 32'hFFFF_0001, 32'h7FFF_0000}, '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F}, '{32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF}
    };
    phase_cfg = '{
      '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF},
      '{24'h0, 24'h0, 24'h0},
      '{24'h00_4000, 24'h03_0000, 24'h00_C000},
      '{24'h10_0000, 24'hF0_8000, 24'h12_0000},
      '{24'h00_0100, 24'h0F_FFFF, 24'h00_0001},
      '{24'h01_0000, 24'h02_0000, 24'h00_8000}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(CFG_SCALE, phase_cfg[ph-1][0]);
        write_reg(CFG_LAC, phase_cfg[ph-1][1]);
        write_reg(CFG_GAIN, phase_cfg[ph-1][2]);
        write_reg(CFG_IDX_W'(3), CFG_DATA_W'($urandom()));
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (ph == 2 && i == 20) hold_req = 1'b1;
        idle_pct = (ph == 3 && i < 120) ? 0 : 32;
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
    end
    drain();
    if (errors == 0) begin
      $display("fbm_value_noise_3d test passed");
    end else begin
      $display("fbm_value_noise_3d test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fbmvn_pkg.sv
rtl/fbmvn_delay.sv
rtl/fbmvn_hash.sv
rtl/fbmvn_lerp.sv
rtl/fbmvn_octave.sv
rtl/fbm_value_noise_3d.sv
sim/fbm_value_noise_3d_tb.sv
